### hw/rtl/gctc_pkg.sv
// Constants, item types and division helpers for the GPS calendar time converter.
package gctc_pkg;

  localparam int NumStages = 13;

  localparam int InDataW  = 96;
  localparam int OutDataW = 104;

  localparam logic [26:0] MsPerDay  = 27'd86400000;
  localparam logic [26:0] MsPerHour = 27'd3600000;
  localparam logic [21:0] MsPerMin  = 22'd60000;
  localparam logic [16:0] MaxWeek   = 17'd32767;
  // epoch offset folded with the date formula constants
  localparam logic [23:0] DayOffset = 24'd723216;
  // MJD of the epoch plus 2400001 plus 68569
  localparam logic [21:0] JdOffset  = 22'd2512814;

  // Reciprocal constants: floor(x/D) = (x*M) >> S for all x below 2**N,
  // with S = N + clog2(D) and M = ceil(2**S / D).
  localparam int          DAY_S = 30 + $clog2(86400000);
  localparam logic [63:0] DAY_M = ((64'd1 << DAY_S) + 64'd86399999) / 64'd86400000;
  localparam int          C100_S = 12 + $clog2(100);
  localparam logic [63:0] C100_M = ((64'd1 << C100_S) + 64'd99) / 64'd100;
  localparam int          SEVEN_S = 21 + $clog2(7);
  localparam logic [63:0] SEVEN_M = ((64'd1 << SEVEN_S) + 64'd6) / 64'd7;
  localparam int          GC_S = 24 + $clog2(146097);
  localparam logic [63:0] GC_M = ((64'd1 << GC_S) + 64'd146096) / 64'd146097;
  localparam int          HR_S = 27 + $clog2(3600000);
  localparam logic [63:0] HR_M = ((64'd1 << HR_S) + 64'd3599999) / 64'd3600000;
  localparam int          MN_S = 22 + $clog2(60000);
  localparam logic [63:0] MN_M = ((64'd1 << MN_S) + 64'd59999) / 64'd60000;
  localparam int          GY_S = 28 + $clog2(1461001);
  localparam logic [63:0] GY_M = ((64'd1 << GY_S) + 64'd1461000) / 64'd1461001;
  localparam int          GM_S = 17 + $clog2(2447);
  localparam logic [63:0] GM_M = ((64'd1 << GM_S) + 64'd2446) / 64'd2447;
  localparam int          E80_S = 17 + $clog2(80);
  localparam logic [63:0] E80_M = ((64'd1 << E80_S) + 64'd79) / 64'd80;

  typedef struct packed {
    logic        mode;
    logic [20:0] y367;
    logic [12:0] aq;
    logic [5:0]  bq;
    logic [8:0]  cq;
    logic [4:0]  dd;
    logic [26:0] tod0;
    logic [23:0] dsum;
    logic [16:0] wk0;
    logic [2:0]  dow;
    logic        err;
    logic [29:0] tow0;
    logic [29:0] tow;
    logic [3:0]  q86;
    logic [17:0] w7;
    logic [21:0] j;
    logic [26:0] tod1;
    logic [6:0]  c;
    logic [4:0]  hour;
    logic [16:0] j2;
    logic [21:0] rem;
    logic [27:0] num;
    logic [5:0]  minute;
    logic [6:0]  yy;
    logic [15:0] ms1;
    logic [9:0]  j3;
    logic [4:0]  mm;
    logic [16:0] t2447;
    logic [9:0]  q80;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [5:0]  q100y;
    logic [8:0]  yday;
  } pipe_t;

  // floor(275*m/9) for every 4-bit month code
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd213;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd366;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd427;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

  // days of a common year before the first of month m
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/gps_calendar_time_converter.sv
// Top level: pipelined two-way conversion between calendar date/time and GPS week/tow.
//
//  channel | dir | handshake          | content
//  in_     | in  | in_tvalid/tready   | tuser: mode; tdata: calendar and week/tow fields
//  out_    | out | out_tvalid/tready  | tuser: range_error; tdata: week/tow and date fields
//
// One item per cycle sustained while out_tready is high, set by the 13-stage pipe.
// Divisions by constants are reciprocal multiplies; no stage chains two of them.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled output holds each full stage with no empty stage after it; empty stages still fill.
module gps_calendar_time_converter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tuser: mode
  input  logic [0:0]                     in_tuser,
  // tdata: cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second_ms,
  //        gps_week_in, tow_ms_in, zero pad
  input  logic [gctc_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tuser: range_error
  output logic [0:0]                     out_tuser,
  // tdata: gps_week_out, tow_ms_out, date_year, date_month, date_day, day_of_year,
  //        time_hour, time_minute, time_second_ms, zero pad
  output logic [gctc_pkg::OutDataW-1:0]  out_tdata
);

  localparam int NS = gctc_pkg::NumStages;

  gctc_pkg::pipe_t s_r   [NS];
  gctc_pkg::pipe_t s_nxt [NS];
  logic [NS-1:0]   v_r;
  logic [NS-1:0]   en;

  logic [11:0] i_y;
  logic [3:0]  i_m;
  logic [1:0]  k12;
  logic [11:0] y2c;
  logic [5:0]  q100;
  logic        e_day;
  logic        k_yr;
  logic [11:0] r100;
  logic        leap;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];

  always_comb begin
    i_y = in_tdata[11:0];
    i_m = in_tdata[15:12];
    k12 = (i_m >= 4'd15) ? 2'd2 : ((i_m >= 4'd3) ? 2'd1 : 2'd0);
    if (i_m <= 4'd2) begin
      y2c = (i_y == 12'd0) ? 12'd0 : i_y - 12'd1;
    end else begin
      y2c = i_y;
    end
    q100 = 6'((64'(y2c) * gctc_pkg::C100_M) >> gctc_pkg::C100_S);

    // stage 0: products and first quotients
    s_nxt[0]       = '0;
    s_nxt[0].mode  = in_tuser[0];
    s_nxt[0].y367  = 21'(i_y) * 21'd367;
    s_nxt[0].aq    = 13'(((15'(i_y) + 15'(k12)) * 15'd7) >> 2);
    s_nxt[0].bq    = 6'(((8'(q100) + 8'd1) * 8'd3) >> 2);
    s_nxt[0].cq    = gctc_pkg::month_term(i_m);
    s_nxt[0].dd    = in_tdata[20:16];
    s_nxt[0].tod0  = 27'(in_tdata[25:21]) * gctc_pkg::MsPerHour
                   + 27'(in_tdata[31:26]) * 27'd60000 + 27'(in_tdata[47:32]);
    s_nxt[0].tow   = in_tdata[92:63];
    s_nxt[0].q86   = 4'((64'(in_tdata[92:63]) * gctc_pkg::DAY_M) >> gctc_pkg::DAY_S);
    s_nxt[0].w7    = 18'(in_tdata[62:48]) * 18'd7;

    // stage 1: day count, carry of time into days, Julian day number plus 68569
    s_nxt[1] = s_r[0];
    e_day = (s_r[0].tod0 >= gctc_pkg::MsPerDay);
    if (e_day) begin
      s_nxt[1].tod0 = s_r[0].tod0 - gctc_pkg::MsPerDay;
    end
    s_nxt[1].dsum = 24'(s_r[0].y367) - 24'(s_r[0].aq) - 24'(s_r[0].bq)
                  + 24'(s_r[0].cq) + 24'(s_r[0].dd) - gctc_pkg::DayOffset + 24'(e_day);
    s_nxt[1].j    = 22'(s_r[0].w7) + 22'(s_r[0].q86) + gctc_pkg::JdOffset;
    s_nxt[1].tod1 = 27'(s_r[0].tow - 30'(s_r[0].q86) * 30'd86400000);

    // stage 2
    s_nxt[2]      = s_r[1];
    s_nxt[2].wk0  = 17'((64'(s_r[1].dsum[20:0]) * gctc_pkg::SEVEN_M) >> gctc_pkg::SEVEN_S);
    s_nxt[2].c    = 7'((64'({s_r[1].j, 2'b00}) * gctc_pkg::GC_M) >> gctc_pkg::GC_S);
    s_nxt[2].hour = 5'((64'(s_r[1].tod1) * gctc_pkg::HR_M) >> gctc_pkg::HR_S);

    // stage 3
    s_nxt[3]     = s_r[2];
    s_nxt[3].dow = 3'(s_r[2].dsum[20:0] - 21'(s_r[2].wk0) * 21'd7);
    s_nxt[3].err = s_r[2].dsum[23] || (s_r[2].wk0 > gctc_pkg::MaxWeek);
    s_nxt[3].j2  = 17'(s_r[2].j - 22'((24'(s_r[2].c) * 24'd146097 + 24'd3) >> 2));
    s_nxt[3].rem = 22'(s_r[2].tod1 - 27'(s_r[2].hour) * gctc_pkg::MsPerHour);

    // stage 4
    s_nxt[4]        = s_r[3];
    s_nxt[4].tow0   = 30'(s_r[3].dow) * 30'd86400000 + 30'(s_r[3].tod0);
    s_nxt[4].num    = (28'(s_r[3].j2) + 28'd1) * 28'd4000;
    s_nxt[4].minute = 6'((64'(s_r[3].rem) * gctc_pkg::MN_M) >> gctc_pkg::MN_S);

    // stage 5
    s_nxt[5]     = s_r[4];
    s_nxt[5].yy  = 7'((64'(s_r[4].num) * gctc_pkg::GY_M) >> gctc_pkg::GY_S);
    s_nxt[5].ms1 = 16'(s_r[4].rem - 22'(s_r[4].minute) * gctc_pkg::MsPerMin);

    // stage 6
    s_nxt[6]    = s_r[5];
    s_nxt[6].j3 = 10'(18'(s_r[5].j2) - ((18'(s_r[5].yy) * 18'd1461) >> 2) + 18'd31);

    // stage 7
    s_nxt[7]    = s_r[6];
    s_nxt[7].mm = 5'((64'(17'(s_r[6].j3) * 17'd80) * gctc_pkg::GM_M) >> gctc_pkg::GM_S);

    // stage 8
    s_nxt[8]       = s_r[7];
    s_nxt[8].t2447 = 17'(s_r[7].mm) * 17'd2447;

    // stage 9
    s_nxt[9]     = s_r[8];
    s_nxt[9].q80 = 10'((64'(s_r[8].t2447) * gctc_pkg::E80_M) >> gctc_pkg::E80_S);

    // stage 10: day, month, year
    s_nxt[10]       = s_r[9];
    k_yr            = (s_r[9].mm >= 5'd11);
    s_nxt[10].day   = 5'(s_r[9].j3 - s_r[9].q80);
    s_nxt[10].month = 4'(s_r[9].mm + 5'd2 - (k_yr ? 5'd12 : 5'd0));
    s_nxt[10].year  = 12'(12'(s_r[9].c - 7'd49) * 12'd100 + 12'(s_r[9].yy) + 12'(k_yr));

    // stage 11
    s_nxt[11]       = s_r[10];
    s_nxt[11].q100y = 6'((64'(s_r[10].year) * gctc_pkg::C100_M) >> gctc_pkg::C100_S);

    // stage 12: leap rule and day of year
    s_nxt[12] = s_r[11];
    r100 = s_r[11].year - 12'(s_r[11].q100y) * 12'd100;
    leap = (s_r[11].year[1:0] == 2'd0) && ((r100 != 12'd0) || (s_r[11].q100y[1:0] == 2'd0));
    s_nxt[12].yday = 9'(s_r[11].day) - 9'd1 + gctc_pkg::month_start(s_r[11].month)
                   + 9'(leap && (s_r[11].month > 4'd2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? in_tvalid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (en[i]) begin
        s_r[i] <= s_nxt[i];
      end
    end
  end

  assign out_tvalid = v_r[NS-1];

  always_comb begin
    out_tdata    = '0;
    out_tuser[0] = 1'b0;
    if (!s_r[NS-1].mode) begin
      out_tuser[0] = s_r[NS-1].err;
      if (!s_r[NS-1].err) begin
        out_tdata[14:0]  = s_r[NS-1].wk0[14:0];
        out_tdata[44:15] = s_r[NS-1].tow0;
      end
    end else begin
      out_tdata[56:45]  = s_r[NS-1].year;
      out_tdata[60:57]  = s_r[NS-1].month;
      out_tdata[65:61]  = s_r[NS-1].day;
      out_tdata[74:66]  = s_r[NS-1].yday;
      out_tdata[79:75]  = s_r[NS-1].hour;
      out_tdata[85:80]  = s_r[NS-1].minute;
      out_tdata[101:86] = s_r[NS-1].ms1;
    end
  end

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[44:0] == 45'd0))
    else $error("range error item carries week or tow");

  a_tow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[44:15] < 30'd604800000))
    else $error("tow out of range");

  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[101:86] < 16'd60000) && (out_tdata[79:75] < 5'd24)
                    && (out_tdata[85:80] < 6'd60)))
    else $error("time of day out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && !out_tready) |=> (v_r[NS-1] && !en[NS-1]) || out_tready)
    else $error("last stage dropped while stalled");
`endif

endmodule

### dv/tb_gps_calendar_time_converter.sv
// Testbench for the GPS calendar time converter: directed table plus random items.
module tb_gps_calendar_time_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CalToGps = 0;
  localparam int GpsToCal = 1;
  localparam int NumDir = 19;

  typedef struct {
    logic [0:0]                    mode;
    logic [gctc_pkg::InDataW-1:0]  data;
    bit                            known;
    logic [0:0]                    exp_user;
    logic [gctc_pkg::OutDataW-1:0] exp_data;
  } request_t;

  typedef struct {
    logic [0:0]                    user;
    logic [gctc_pkg::OutDataW-1:0] data;
  } result_t;

  // fld: year, month, day, hour, minute, ms, week, tow
  // exp: week, tow, year, month, day, doy, hour, minute, ms, range_error
  typedef struct {
    int mode;
    int fld[8];
    bit known;
    int exp[10];
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [0:0]                    in_tuser = '0;
  logic [gctc_pkg::InDataW-1:0]  in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [0:0]                    out_tuser;
  logic [gctc_pkg::OutDataW-1:0] out_tdata;

  request_t request_q[$];
  result_t  pending_results[$];
  request_t cur_req;
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // extremes with typed-in results, then leap rules, unchecked fields, carries,
  // largest inputs
  dir_row_t dir_tab[NumDir] = '{
    '{CalToGps, '{1980, 1, 6, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{CalToGps, '{1980, 1, 6, 23, 59, 59999, 0, 0}, 1'b1,
      '{0, 86399999, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{CalToGps, '{1980, 1, 5, 23, 59, 59999, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1}},
    '{CalToGps, '{4095, 12, 31, 23, 59, 59999, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1}},
    '{GpsToCal, '{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1980, 1, 6, 5, 0, 0, 0, 0}},
    '{GpsToCal, '{0, 0, 0, 0, 0, 0, 0, 604799999}, 1'b1,
      '{0, 0, 1980, 1, 12, 11, 23, 59, 59999, 0}},
    '{CalToGps, '{2000, 2, 29, 12, 30, 30500, 0, 0}, 1'b0, '{10{0}}},
    '{CalToGps, '{2100, 3, 1, 0, 0, 0, 0, 0}, 1'b0, '{10{0}}},
    '{CalToGps, '{2400, 12, 31, 23, 59, 60999, 0, 0}, 1'b0, '{10{0}}},
    '{CalToGps, '{2024, 0, 15, 1, 2, 3, 0, 0}, 1'b0, '{10{0}}},
    '{CalToGps, '{2024, 15, 0, 31, 63, 65535, 32767, 0}, 1'b0, '{10{0}}},
    '{CalToGps, '{2607, 12, 31, 23, 59, 59999, 0, 0}, 1'b0, '{10{0}}},
    '{CalToGps, '{2608, 1, 1, 0, 0, 0, 0, 0}, 1'b0, '{10{0}}},
    '{CalToGps, '{0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '{10{0}}},
    '{GpsToCal, '{0, 0, 0, 0, 0, 0, 32767, 1073741823}, 1'b0, '{10{0}}},
    '{GpsToCal, '{0, 0, 0, 0, 0, 0, 1042, 86400000}, 1'b0, '{10{0}}},
    '{GpsToCal, '{0, 0, 0, 0, 0, 0, 1095, 172800000}, 1'b0, '{10{0}}},
    '{GpsToCal, '{0, 0, 0, 0, 0, 0, 6314, 345599999}, 1'b0, '{10{0}}},
    '{GpsToCal, '{4095, 15, 31, 31, 63, 65535, 12345, 5}, 1'b0, '{10{0}}}
  };

  gps_calendar_time_converter uut (.*);

  initial forever #5 clk = ~clk;

  function automatic logic [gctc_pkg::InDataW-1:0] pack_in(int y, int mo, int d, int h,
                                                           int mi, int ms, int wk, int tow);
    logic [gctc_pkg::InDataW-1:0] v;
    v = '0;
    v[11:0]  = 12'(y);
    v[15:12] = 4'(mo);
    v[20:16] = 5'(d);
    v[25:21] = 5'(h);
    v[31:26] = 6'(mi);
    v[47:32] = 16'(ms);
    v[62:48] = 15'(wk);
    v[92:63] = 30'(tow);
    return v;
  endfunction

  function automatic logic [gctc_pkg::OutDataW-1:0] pack_out(longint wk, longint tow,
                                                             longint y, longint mo,
                                                             longint d, longint doy,
                                                             longint h, longint mi,
                                                             longint ms);
    logic [gctc_pkg::OutDataW-1:0] v;
    v = '0;
    v[14:0]   = wk[14:0];
    v[44:15]  = tow[29:0];
    v[56:45]  = y[11:0];
    v[60:57]  = mo[3:0];
    v[65:61]  = d[4:0];
    v[74:66]  = doy[8:0];
    v[79:75]  = h[4:0];
    v[85:80]  = mi[5:0];
    v[101:86] = ms[15:0];
    return v;
  endfunction

  function automatic result_t convert_time(logic [0:0] mode,
                                           logic [gctc_pkg::InDataW-1:0] din);
    result_t r;
    longint y, m, d, mjd, inst, wk, tow, tod, j, c, yy, mm, k, doy;
    int mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    r.user = 1'b0;
    r.data = '0;
    if (mode == CalToGps) begin
      y = longint'(din[11:0]);
      m = longint'(din[15:12]);
      d = longint'(din[20:16]);
      mjd = 367 * y - 7 * (y + (m + 9) / 12) / 4 - 3 * ((y + (m - 9) / 7) / 100 + 1) / 4
            + 275 * m / 9 + d + 1721028 - 2400000;
      inst = (mjd - 44244) * 64'd86400000 + longint'(din[25:21]) * 3600000
             + longint'(din[31:26]) * 60000 + longint'(din[47:32]);
      if (inst < 0) begin
        r.user = 1'b1;
      end else begin
        wk = inst / 64'd604800000;
        if (wk > 32767) r.user = 1'b1;
        else r.data = pack_out(wk, inst % 64'd604800000, 0, 0, 0, 0, 0, 0, 0);
      end
    end else begin
      wk = longint'(din[62:48]);
      tow = longint'(din[92:63]);
      mjd = 44244 + wk * 7 + tow / 64'd86400000;
      tod = tow % 64'd86400000;
      j = mjd + 2400001 + 68569;
      c = 4 * j / 146097;
      j = j - (146097 * c + 3) / 4;
      yy = 4000 * (j + 1) / 1461001;
      j = j - 1461 * yy / 4 + 31;
      mm = 80 * j / 2447;
      d = j - 2447 * mm / 80;
      k = mm / 11;
      m = mm + 2 - 12 * k;
      y = 100 * (c - 49) + yy + k;
      doy = d - 1;
      for (int i = 0; i < 12 && i < m - 1; i++) begin
        doy += mlen[i];
        if (i == 1 && y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) doy += 1;
      end
      r.data = pack_out(0, 0, y, m, d, doy, tod / 3600000, (tod % 3600000) / 60000,
                        tod % 60000);
    end
    return r;
  endfunction

  function automatic request_t mk(int mode, logic [gctc_pkg::InDataW-1:0] din);
    request_t q;
    q.mode = 1'(mode);
    q.data = din;
    q.known = 1'b0;
    q.exp_user = '0;
    q.exp_data = '0;
    return q;
  endfunction

  function automatic request_t mk_known(int mode, logic [gctc_pkg::InDataW-1:0] din,
                                        logic eu, logic [gctc_pkg::OutDataW-1:0] ed);
    request_t q;
    q = mk(mode, din);
    q.known = 1'b1;
    q.exp_user = eu;
    q.exp_data = ed;
    return q;
  endfunction

  function automatic request_t rand_request();
    int mode;
    logic [gctc_pkg::InDataW-1:0] v;
    mode = $urandom_range(1);
    v = pack_in($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
    if (mode == CalToGps && $urandom_range(99) < 80)
      v[47:0] = 48'(pack_in($urandom_range(2400, 1980), $urandom_range(12, 1),
                            $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                            $urandom_range(60999), 0, 0));
    if (mode == GpsToCal && $urandom_range(99) < 70)
      v[92:63] = 30'($urandom_range(604799999));
    return mk(mode, v);
  endfunction

  function automatic void add_request(request_t q);
    request_q.insert(request_q.size(), q);
  endfunction

  // driver: one item per accepted handshake
  always @(posedge clk) begin
    result_t er;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        er = convert_time(cur_req.mode, cur_req.data);
        if (cur_req.known) begin
          er.user = cur_req.exp_user;
          er.data = cur_req.exp_data;
        end
        pending_results.insert(pending_results.size(), er);
      end
      if (!in_tvalid || in_tready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = request_q.pop_front();
          in_tuser <= cur_req.mode;
          in_tdata <= cur_req.data;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // checker
  always @(posedge clk) begin
    result_t er;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected item user=%h data=%h", $time, out_tuser, out_tdata);
          errors++;
        end else begin
          er = pending_results.pop_front();
          if (er.user !== out_tuser || er.data !== out_tdata) begin
            $display("%0t: mismatch expected user=%h data=%h actual user=%h data=%h",
                     $time, er.user, er.data, out_tuser, out_tdata);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int send_pct[4] = '{0, 69, 0, 19};
    int recv_pct[4] = '{0, 0, 69, 19};
    request_t req;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NumDir; r++) begin
      req = mk(dir_tab[r].mode,
               pack_in(dir_tab[r].fld[0], dir_tab[r].fld[1], dir_tab[r].fld[2],
                       dir_tab[r].fld[3], dir_tab[r].fld[4], dir_tab[r].fld[5],
                       dir_tab[r].fld[6], dir_tab[r].fld[7]));
      if (dir_tab[r].known) begin
        req = mk_known(dir_tab[r].mode, req.data, 1'(dir_tab[r].exp[9]),
                       pack_out(dir_tab[r].exp[0], dir_tab[r].exp[1], dir_tab[r].exp[2],
                                dir_tab[r].exp[3], dir_tab[r].exp[4], dir_tab[r].exp[5],
                                dir_tab[r].exp[6], dir_tab[r].exp[7], dir_tab[r].exp[8]));
      end
      add_request(req);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      repeat (490) add_request(rand_request());
      while (request_q.size() != 0 || in_tvalid || pending_results.size() != 0)
        @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
